>>> src/jssg_pkg.sv
// Shared types and constants for the JTAG scan sequence generator.
// No dependencies; imported by jssg_seq and jtag_scan_sequence_generator.
package jssg_pkg;

   // Default data word width
   localparam int WORD_WIDTH_DEF = 32;

   // Width of the bit-count field and of the step counter
   localparam int BITS_W = 6;

   // Command codes
   localparam logic [1:0] CMD_RESET  = 2'd0;
   localparam logic [1:0] CMD_IR     = 2'd1;
   localparam logic [1:0] CMD_DR     = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // TMS patterns, sent LSB first
   localparam int PAT_W = 6;
   localparam logic [PAT_W-1:0] RESET_PAT     = 6'b011111; // 1,1,1,1,1,0
   localparam logic [PAT_W-1:0] IR_HEAD_PAT   = 6'b000110; // 0,1,1,0,0
   localparam logic [PAT_W-1:0] DR_HEAD_PAT   = 6'b000010; // 0,1,0,0
   localparam logic [PAT_W-1:0] DR_PAUSE_PAT  = 6'b000111; // 1,1,1,0,0
   localparam logic [1:0]       TAIL_IDLE_PAT  = 2'b01;    // 1,0
   localparam logic [1:0]       TAIL_PAUSE_PAT = 2'b00;    // 0,0

   // Pattern lengths
   localparam logic [BITS_W-1:0] RESET_LEN    = 6'd6;
   localparam logic [BITS_W-1:0] IR_HEAD_LEN  = 6'd5;
   localparam logic [BITS_W-1:0] DR_HEAD_LEN  = 6'd4;
   localparam logic [BITS_W-1:0] DR_PAUSE_LEN = 6'd5;
   localparam logic [BITS_W-1:0] TAIL_LEN     = 6'd2;

   // One pin step
   typedef struct packed {
      logic tms;
      logic tdi;
      logic run_end;
   } step_type;

endpackage

>>> src/jssg_seq.sv
// Step sequencer for the JTAG scan sequence generator: header, shift, tail.
// Depends on jssg_pkg.
module jssg_seq #(
   parameter int WORD_WIDTH = jssg_pkg::WORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    command,
   input  logic [WORD_WIDTH-1:0]         data_word,
   input  logic [jssg_pkg::BITS_W-1:0]   word_bits,
   input  logic                          first_word,
   input  logic                          last_word,
   input  logic                          end_in_ir_pause,
   input  logic                          advance,
   output logic                          busy,
   output jssg_pkg::step_type            step
);
   import jssg_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_HEAD, S_SHIFT, S_TAIL} state_type;

   state_type             state_ff, state_in;
   logic [PAT_W-1:0]      pat_ff, pat_in;
   logic [BITS_W-1:0]     cnt_ff, cnt_in;
   logic [BITS_W-1:0]     bits_ff, bits_in;
   logic [WORD_WIDTH-1:0] data_ff, data_in;
   logic                  last_ff, last_in;
   logic [1:0]            tail_ff, tail_in;
   logic [BITS_W-1:0]     bits_sat;
   logic                  cnt_one;

   // Clamp the bit count to the word width
   assign bits_sat = (word_bits > BITS_W'(WORD_WIDTH)) ? BITS_W'(WORD_WIDTH) : word_bits;
   assign cnt_one  = (cnt_ff == BITS_W'(1));
   assign busy     = (state_ff != S_IDLE);

   // Current step
   always_comb begin
      step = '0;
      case (state_ff)
         S_HEAD: begin
            step.tms     = pat_ff[0];
            step.run_end = cnt_one && (bits_ff == '0) && !last_ff;
         end
         S_SHIFT: begin
            step.tdi     = data_ff[0];
            step.tms     = last_ff && cnt_one;
            step.run_end = cnt_one && !last_ff;
         end
         S_TAIL: begin
            step.tms     = pat_ff[0];
            step.run_end = cnt_one;
         end
         default: step = '0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      pat_in   = pat_ff;
      cnt_in   = cnt_ff;
      bits_in  = bits_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      tail_in  = tail_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (command == CMD_RESET) begin
                  state_in = S_HEAD;
                  pat_in   = RESET_PAT;
                  cnt_in   = RESET_LEN;
                  bits_in  = '0;
                  last_in  = 1'b0;
               end else if (command == CMD_IR || command == CMD_DR) begin
                  bits_in = bits_sat;
                  last_in = last_word;
                  data_in = data_word;
                  tail_in = (command == CMD_IR && end_in_ir_pause) ? TAIL_PAUSE_PAT
                                                                   : TAIL_IDLE_PAT;
                  if (first_word) begin
                     state_in = S_HEAD;
                     if (command == CMD_IR) begin
                        pat_in = IR_HEAD_PAT;
                        cnt_in = IR_HEAD_LEN;
                     end else if (end_in_ir_pause) begin
                        pat_in = DR_PAUSE_PAT;
                        cnt_in = DR_PAUSE_LEN;
                     end else begin
                        pat_in = DR_HEAD_PAT;
                        cnt_in = DR_HEAD_LEN;
                     end
                  end else if (bits_sat != '0) begin
                     state_in = S_SHIFT;
                     cnt_in   = bits_sat;
                  end else if (last_word) begin
                     state_in = S_TAIL;
                     pat_in   = {{(PAT_W-2){1'b0}}, tail_in};
                     cnt_in   = TAIL_LEN;
                  end
               end
            end
         end
         S_HEAD: begin
            if (advance) begin
               pat_in = pat_ff >> 1;
               cnt_in = cnt_ff - BITS_W'(1);
               if (cnt_one) begin
                  if (bits_ff != '0) begin
                     state_in = S_SHIFT;
                     cnt_in   = bits_ff;
                  end else if (last_ff) begin
                     state_in = S_TAIL;
                     pat_in   = {{(PAT_W-2){1'b0}}, tail_ff};
                     cnt_in   = TAIL_LEN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_SHIFT: begin
            if (advance) begin
               data_in = data_ff >> 1;
               cnt_in  = cnt_ff - BITS_W'(1);
               if (cnt_one) begin
                  if (last_ff) begin
                     state_in = S_TAIL;
                     pat_in   = {{(PAT_W-2){1'b0}}, tail_ff};
                     cnt_in   = TAIL_LEN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_TAIL: begin
            if (advance) begin
               pat_in = pat_ff >> 1;
               cnt_in = cnt_ff - BITS_W'(1);
               if (cnt_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pat_ff  <= pat_in;
      cnt_ff  <= cnt_in;
      bits_ff <= bits_in;
      data_ff <= data_in;
      last_ff <= last_in;
      tail_ff <= tail_in;
   end

endmodule

>>> src/jtag_scan_sequence_generator.sv
// JTAG scan sequence generator: top level with request, response and csr ports.
// Depends on jssg_pkg and jssg_seq.
//
// Usage:
//  - req_*: one request is a scan command (TAP reset, IR shift, DR shift) with
//    one data word. Command 3 is dropped and produces no response.
//  - rsp_*: one response per TCK step, carrying tms and tdi; rsp_run_end marks
//    the last step produced by a request.
//  - csr_*: writes end_in_ir_pause; always ready. Write only while idle.
// Timing:
//  - A request produces up to 39 steps (5 header, 32 bits, 2 tail) at the
//    default word width, one per cycle while rsp takes them. Each step is
//    registered in the sequencer, then in the output register on rsp.
//  - req_ready is high only while the sequencer is idle, so a new request
//    waits until the sequencer has produced every step of the last one; it
//    can be taken while that final step still waits in the output register.
//  - If rsp_valid is high and rsp_ready low, the sequencer holds; no step is lost.
//  - Reset (synchronous) clears the sequencer, the output valid and
//    end_in_ir_pause.
module jtag_scan_sequence_generator #(
   parameter int WORD_WIDTH = jssg_pkg::WORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [WORD_WIDTH-1:0]       req_data_word,
   input  logic [jssg_pkg::BITS_W-1:0] req_word_bits,
   input  logic                        req_first_word,
   input  logic                        req_last_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_tms,
   output logic                        rsp_tdi,
   output logic                        rsp_run_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_end_in_ir_pause
);
   import jssg_pkg::*;

   logic     pause_ff, pause_in;
   logic     rsp_valid_ff, rsp_valid_in;
   step_type rsp_step_ff, rsp_step_in;
   step_type step;
   logic     busy;
   logic     start;
   logic     advance;

   assign req_ready = !busy;
   assign start     = req_valid && req_ready;
   assign advance   = busy && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // Step sequencer
   jssg_seq #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .command         (req_command),
      .data_word       (req_data_word),
      .word_bits       (req_word_bits),
      .first_word      (req_first_word),
      .last_word       (req_last_word),
      .end_in_ir_pause (pause_ff),
      .advance         (advance),
      .busy            (busy),
      .step            (step)
   );

   // Config register
   assign pause_in = (csr_valid && csr_ready) ? csr_end_in_ir_pause : pause_ff;

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_step_in  = rsp_step_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_step_in  = step;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pause_ff     <= pause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_step_ff <= rsp_step_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tms     = rsp_step_ff.tms;
   assign rsp_tdi     = rsp_step_ff.tdi;
   assign rsp_run_end = rsp_step_ff.run_end;

endmodule
